/* hw/rtl/qrr_pkg.sv */
`default_nettype none
package qrr_pkg;
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int QDEPTH = 4;

  typedef enum logic [1:0] {
    ST_TWO   = 2'd0,
    ST_NONE  = 2'd1,
    ST_AZERO = 2'd2,
    ST_SAT   = 2'd3
  } status_t;
endpackage
`default_nettype wire

/* hw/rtl/quadratic_real_roots_unit.sv */
`default_nettype none
// Real roots of a*x^2 + b*x + c, signed fixed point (Q16.16 by default).
// Input channel in_valid/in_ready carries coef_a, coef_b, coef_c; result
// channel out_valid/out_ready carries root_plus, root_minus, status
// (0 two roots, 1 none, 2 a is zero, 3 saturated). One result per item,
// in order.
// Throughput: one item per cycle while out_ready is high. The front part
// (products, discriminant, pipelined square root, 2 bits a stage) feeds a
// short FIFO; the back part (two pipelined dividers, one quotient bit a
// stage, then saturation) drains it when the output side can take items.
// Path from the input transfer to out_valid: 2 front stages (products,
// discriminant), the root stages, FIFO write and registered read, the
// divider stages, then the output register.
// While a result waits with out_ready low, the back pipeline and FIFO read
// freeze; the front keeps running and in_ready drops once the FIFO cannot
// absorb the items in flight.
// Synchronous reset clears all valid flags and the FIFO.
module quadratic_real_roots_unit #(
  parameter int FRAC_BITS = qrr_pkg::FRAC_BITS,
  parameter int WORD_BITS = qrr_pkg::WORD_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [WORD_BITS-1:0] in_coef_a,
  input  wire logic signed [WORD_BITS-1:0] in_coef_b,
  input  wire logic signed [WORD_BITS-1:0] in_coef_c,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [WORD_BITS-1:0]      out_root_plus,
  output logic signed [WORD_BITS-1:0]      out_root_minus,
  output logic [1:0]                       out_status
);
  localparam int SW = WORD_BITS + 1;
  localparam int FLAT = 3 + (SW + 1) / 2;
  localparam int QD = FLAT + qrr_pkg::QDEPTH;
  localparam int QW = 2 * WORD_BITS + SW + 2;
  localparam int CW = $clog2(QD + 1);

  logic                        fv;
  logic signed [WORD_BITS-1:0] fa, fb;
  logic [SW-1:0]               fs;
  qrr_pkg::status_t            fst;
  logic                        q_empty;
  logic [CW-1:0]               q_cnt;
  logic [QW-1:0]               q_rd;
  logic [$clog2(FLAT+1)-1:0]   infl_r;
  logic                        qv_r;
  logic                        acc, back_en, q_rd_en;
  logic                        bv;
  logic signed [WORD_BITS-1:0] brp, brm;
  qrr_pkg::status_t            bst;

  // items in the front pipeline, tracked so the FIFO never overflows
  assign in_ready = (32'(q_cnt) + 32'(infl_r)) < QD;
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) infl_r <= '0;
    else infl_r <= infl_r + (acc ? 1'b1 : 1'b0) - (fv ? 1'b1 : 1'b0);
  end

  qrr_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk, .rst_n, .en(1'b1), .in_valid(acc),
    .a_in(in_coef_a), .b_in(in_coef_b), .c_in(in_coef_c),
    .v_out(fv), .a_out(fa), .b_out(fb), .s_out(fs), .st_out(fst)
  );

  qrr_queue #(.W(QW), .DEPTH(QD)) u_queue (
    .clk, .rst_n, .wr_en(fv), .wr_data({fa, fb, fs, fst}),
    .rd_en(q_rd_en), .rd_data(q_rd), .empty(q_empty), .count(q_cnt)
  );

  assign back_en = !out_valid || out_ready;
  assign q_rd_en = back_en && !q_empty;

  // FIFO read data is registered; this flags that it holds an item
  always_ff @(posedge clk) begin
    if (!rst_n) qv_r <= 1'b0;
    else if (back_en) qv_r <= q_rd_en;
  end

  qrr_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
    .clk, .rst_n, .en(back_en), .v_in(qv_r),
    .a_in(q_rd[QW-1 -: WORD_BITS]), .b_in(q_rd[QW-WORD_BITS-1 -: WORD_BITS]),
    .s_in(q_rd[SW+1:2]), .st_in(qrr_pkg::status_t'(q_rd[1:0])),
    .v_out(bv), .rp_out(brp), .rm_out(brm), .st_out(bst)
  );

  assign out_valid = bv;
  assign out_root_plus = brp;
  assign out_root_minus = brm;
  assign out_status = bst;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(fv && !q_rd_en && (32'(q_cnt) == QD))) else $error("queue overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_root_plus))
    else $error("result changed under stall");
  a_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == qrr_pkg::ST_NONE || out_status == qrr_pkg::ST_AZERO)
    |-> out_root_plus == '0 && out_root_minus == '0) else $error("roots not zero");
`endif
endmodule
`default_nettype wire

/* hw/rtl/qrr_front.sv */
`default_nettype none
// Front part: one pipeline stage per step. Squares and products, then the
// discriminant and classification, then a pipelined square root.
module qrr_front #(
  parameter int WORD_BITS = qrr_pkg::WORD_BITS,
  localparam int DW = 2 * WORD_BITS + 2,
  localparam int SW = WORD_BITS + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic signed [WORD_BITS-1:0] a_in,
  input  wire logic signed [WORD_BITS-1:0] b_in,
  input  wire logic signed [WORD_BITS-1:0] c_in,
  output logic                             v_out,
  output logic signed [WORD_BITS-1:0]      a_out,
  output logic signed [WORD_BITS-1:0]      b_out,
  output logic [SW-1:0]                    s_out,
  output qrr_pkg::status_t                 st_out
);
  // stage 1: products
  logic                        v1_r;
  logic signed [WORD_BITS-1:0] a1_r, b1_r;
  logic [2*WORD_BITS-1:0]      b2_r, ac_r;
  logic                        sgn_same_r;
  logic [WORD_BITS-1:0]        am, bm, cm;

  always_comb begin
    am = a_in[WORD_BITS-1] ? WORD_BITS'(-a_in) : WORD_BITS'(a_in);
    bm = b_in[WORD_BITS-1] ? WORD_BITS'(-b_in) : WORD_BITS'(b_in);
    cm = c_in[WORD_BITS-1] ? WORD_BITS'(-c_in) : WORD_BITS'(c_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      a1_r <= a_in;
      b1_r <= b_in;
      b2_r <= bm * bm;
      ac_r <= am * cm;
      sgn_same_r <= (a_in != '0) && (c_in != '0) &&
                    (a_in[WORD_BITS-1] == c_in[WORD_BITS-1]);
    end
  end

  // stage 2: discriminant
  logic [DW-1:0] b2x, p4x, d_c;
  logic          pos_c;
  logic          v2_r;
  logic signed [WORD_BITS-1:0] a2_r, b2s_r;
  logic [DW-1:0] d2_r;
  qrr_pkg::status_t st2_r;

  always_comb begin
    b2x = DW'(b2_r);
    p4x = {ac_r, 2'b00};
    if (sgn_same_r) begin
      pos_c = b2x > p4x;
      d_c = pos_c ? b2x - p4x : '0;
    end else begin
      d_c = b2x + p4x;
      pos_c = d_c != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      a2_r <= a1_r;
      b2s_r <= b1_r;
      d2_r <= d_c;
      if (!pos_c) st2_r <= qrr_pkg::ST_NONE;
      else if (a1_r == '0) st2_r <= qrr_pkg::ST_AZERO;
      else st2_r <= qrr_pkg::ST_TWO;
    end
  end

  // square root: two result bits per stage, restoring
  localparam int NST = (SW + 1) / 2;
  localparam int RB = 2 * NST;
  localparam int RW = RB + 2;
  logic                        sv_r  [NST+1];
  logic signed [WORD_BITS-1:0] sa_r  [NST+1];
  logic signed [WORD_BITS-1:0] sb_r  [NST+1];
  logic [2*RB-1:0]             sd_r  [NST+1];
  logic [RW-1:0]               srem_r[NST+1];
  logic [RB-1:0]               sq_r  [NST+1];
  qrr_pkg::status_t            sst_r [NST+1];

  always_comb begin
    sv_r[0] = v2_r;
    sa_r[0] = a2_r;
    sb_r[0] = b2s_r;
    sd_r[0] = (2*RB)'(d2_r);
    srem_r[0] = '0;
    sq_r[0] = '0;
    sst_r[0] = st2_r;
  end

  for (genvar g = 0; g < NST; g++) begin : g_sq
    logic [RW-1:0] r1, r2, t1, t2;
    logic [RB-1:0] q1, q2;
    logic [2*RB-1:0] d1, d2;
    always_comb begin
      d1 = sd_r[g];
      q1 = sq_r[g];
      r1 = RW'({srem_r[g], d1[2*RB-1 -: 2]});
      t1 = RW'({q1, 2'b01});
      if (r1 >= t1) begin
        r1 = r1 - t1;
        q1 = {q1[RB-2:0], 1'b1};
      end else begin
        q1 = {q1[RB-2:0], 1'b0};
      end
      d2 = d1 << 2;
      r2 = RW'({r1, d2[2*RB-1 -: 2]});
      t2 = RW'({q1, 2'b01});
      q2 = q1;
      if (r2 >= t2) begin
        r2 = r2 - t2;
        q2 = {q1[RB-2:0], 1'b1};
      end else begin
        q2 = {q1[RB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[g+1] <= 1'b0;
      end else if (en) begin
        sv_r[g+1] <= sv_r[g];
      end
      if (en) begin
        sa_r[g+1] <= sa_r[g];
        sb_r[g+1] <= sb_r[g];
        sd_r[g+1] <= d2 << 2;
        srem_r[g+1] <= r2;
        sq_r[g+1] <= q2;
        sst_r[g+1] <= sst_r[g];
      end
    end
  end

  assign v_out = sv_r[NST];
  assign a_out = sa_r[NST];
  assign b_out = sb_r[NST];
  assign s_out = SW'(sq_r[NST]);
  assign st_out = sst_r[NST];
endmodule
`default_nettype wire

/* hw/rtl/qrr_queue.sv */
`default_nettype none
// Small FIFO between front and back; the parent sizes its depth to leave room for items in flight.
// Read data is registered: it shows up the cycle after rd_en.
module qrr_queue #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);
  logic [W-1:0]  mem_r [DEPTH];
  logic [W-1:0]  rd_data_r;
  logic [AW-1:0] wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
    if (rd_en) rd_data_r <= mem_r[rp_r];
  end

  assign rd_data = rd_data_r;
  assign empty = cnt_r == '0;
  assign count = cnt_r;
endmodule
`default_nettype wire

/* hw/rtl/qrr_back.sv */
`default_nettype none
// Back part: two pipelined restoring dividers, one quotient bit per stage,
// then saturation and the output register.
module qrr_back #(
  parameter int FRAC_BITS = qrr_pkg::FRAC_BITS,
  parameter int WORD_BITS = qrr_pkg::WORD_BITS,
  localparam int SW = WORD_BITS + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        v_in,
  input  wire logic signed [WORD_BITS-1:0] a_in,
  input  wire logic signed [WORD_BITS-1:0] b_in,
  input  wire logic [SW-1:0]               s_in,
  input  wire qrr_pkg::status_t            st_in,
  output logic                             v_out,
  output logic signed [WORD_BITS-1:0]      rp_out,
  output logic signed [WORD_BITS-1:0]      rm_out,
  output qrr_pkg::status_t                 st_out
);
  localparam int NW = WORD_BITS + 2 + FRAC_BITS;  // numerator magnitude
  localparam int DVW = WORD_BITS + 1;            // 2|a|
  localparam int NST = NW;
  localparam int RW = DVW + 1;

  logic signed [WORD_BITS+1:0] np, nm;
  logic [WORD_BITS:0] dm;
  always_comb begin
    np = (WORD_BITS+2)'(-b_in) + (WORD_BITS+2)'($signed({1'b0, s_in}));
    nm = (WORD_BITS+2)'(-b_in) - (WORD_BITS+2)'($signed({1'b0, s_in}));
    dm = a_in[WORD_BITS-1] ? {(WORD_BITS)'(-a_in), 1'b0} : {a_in, 1'b0};
  end

  logic             v_r   [NST+1];
  logic [DVW-1:0]   dv_r  [NST+1];
  logic [NW-1:0]    np_r  [NST+1];
  logic [NW-1:0]    nm_r  [NST+1];
  logic [RW-1:0]    rp_r  [NST+1];
  logic [RW-1:0]    rm_r  [NST+1];
  logic             ngp_r [NST+1];
  logic             ngm_r [NST+1];
  qrr_pkg::status_t st_r  [NST+1];

  always_comb begin
    v_r[0] = v_in;
    dv_r[0] = dm;
    np_r[0] = {(np[WORD_BITS+1] ? (WORD_BITS+2)'(-np) : np), {FRAC_BITS{1'b0}}};
    nm_r[0] = {(nm[WORD_BITS+1] ? (WORD_BITS+2)'(-nm) : nm), {FRAC_BITS{1'b0}}};
    rp_r[0] = '0;
    rm_r[0] = '0;
    ngp_r[0] = (np != '0) && (np[WORD_BITS+1] != a_in[WORD_BITS-1]);
    ngm_r[0] = (nm != '0) && (nm[WORD_BITS+1] != a_in[WORD_BITS-1]);
    st_r[0] = st_in;
  end

  // numerator register shifts out its top bit and takes quotient bits in low
  for (genvar g = 0; g < NST; g++) begin : g_div
    logic [RW-1:0] tp, tm;
    logic          kp, km;
    always_comb begin
      tp = {rp_r[g][RW-2:0], np_r[g][NW-1]};
      tm = {rm_r[g][RW-2:0], nm_r[g][NW-1]};
      kp = tp >= RW'(dv_r[g]);
      km = tm >= RW'(dv_r[g]);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
      if (en) begin
        dv_r[g+1] <= dv_r[g];
        rp_r[g+1] <= kp ? tp - RW'(dv_r[g]) : tp;
        rm_r[g+1] <= km ? tm - RW'(dv_r[g]) : tm;
        np_r[g+1] <= {np_r[g][NW-2:0], kp};
        nm_r[g+1] <= {nm_r[g][NW-2:0], km};
        ngp_r[g+1] <= ngp_r[g];
        ngm_r[g+1] <= ngm_r[g];
        st_r[g+1] <= st_r[g];
      end
    end
  end

  function automatic logic [WORD_BITS:0] clamp(input logic [NW-1:0] q, input logic neg);
    logic [NW-1:0] lim;
    begin
      lim = NW'(1) << (WORD_BITS - 1);
      if (neg) begin
        if (q > lim) clamp = {1'b1, lim[WORD_BITS-1:0]};
        else clamp = {1'b0, WORD_BITS'(-q[WORD_BITS-1:0])};
      end else begin
        if (q > lim - 1'b1) clamp = {1'b1, WORD_BITS'(lim - 1'b1)};
        else clamp = {1'b0, q[WORD_BITS-1:0]};
      end
    end
  endfunction

  logic [WORD_BITS:0] cp, cm;
  logic               vo_r;
  logic [WORD_BITS-1:0] rpo_r, rmo_r;
  qrr_pkg::status_t   sto_r;

  always_comb begin
    cp = clamp(np_r[NST], ngp_r[NST]);
    cm = clamp(nm_r[NST], ngm_r[NST]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[NST];
    end
    if (en) begin
      if (st_r[NST] != qrr_pkg::ST_TWO) begin
        rpo_r <= '0;
        rmo_r <= '0;
        sto_r <= st_r[NST];
      end else begin
        rpo_r <= cp[WORD_BITS-1:0];
        rmo_r <= cm[WORD_BITS-1:0];
        sto_r <= (cp[WORD_BITS] || cm[WORD_BITS]) ? qrr_pkg::ST_SAT : qrr_pkg::ST_TWO;
      end
    end
  end

  assign v_out = vo_r;
  assign rp_out = rpo_r;
  assign rm_out = rmo_r;
  assign st_out = sto_r;
endmodule
`default_nettype wire
